// ===== rtl/iutc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package iutc_pkg;

  typedef enum logic [2:0] {
    ERR_OK     = 3'd0,
    ERR_LENGTH = 3'd1,
    ERR_FIELDS = 3'd2,
    ERR_MILLIS = 3'd3,
    ERR_NO_Z   = 3'd4,
    ERR_RANGE  = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_REM,
    B_DOE,
    B_SUM,
    B_OUT
  } back_state_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_Z     = 8'h5A;

  localparam logic [4:0] POS_LAST_SHORT = 5'd19;
  localparam logic [4:0] POS_LAST_LONG  = 5'd23;
  localparam logic [4:0] POS_MAX        = 5'd31;

  localparam logic [12:0] RECIP_400   = 13'd5243;  // 2^21 / 400, rounded up
  localparam int          RECIP_SHIFT = 21;

  typedef struct packed {
    err_t        err;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millis;
  } entry_t;

  // days before the start of each March-based month
  function automatic logic [8:0] month_offset(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/iutc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface iutc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       is_last;

  modport source (output valid, char_in, is_last, input ready);
  modport sink   (input valid, char_in, is_last, output ready);
endinterface

interface iutc_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         error_code;
  logic signed [22:0] days_since_epoch;
  logic [26:0]        ms_of_day;

  modport source (output valid, error_code, days_since_epoch, ms_of_day, input ready);
  modport sink   (input valid, error_code, days_since_epoch, ms_of_day, output ready);
endinterface

`default_nettype wire

// ===== rtl/iutc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module iutc_front
  import iutc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  iutc_char_if.sink   req,
  output entry_t      push_data,
  output logic        push,
  input  wire logic   q_full
);

  logic [4:0]  pos, pos_next;
  logic [13:0] year, year_next;
  logic [6:0]  month, month_next;
  logic [6:0]  day, day_next;
  logic [6:0]  hour, hour_next;
  logic [6:0]  minute, minute_next;
  logic [6:0]  second, second_next;
  logic [9:0]  millis, millis_next;
  logic        fields_bad, fields_bad_next;
  logic        millis_bad, millis_bad_next;

  logic       accept;
  logic       dig;
  logic [3:0] d;
  logic       long_form;
  logic [9:0] mil;
  logic       out_of_range;
  err_t       err;

  assign req.ready = !q_full;
  assign accept    = req.valid && req.ready;
  assign dig       = (req.char_in >= CH_ZERO) && (req.char_in <= CH_NINE);
  assign d         = dig ? req.char_in[3:0] : 4'd0;

  always_comb begin
    pos_next        = (pos == POS_MAX) ? pos : pos + 5'd1;
    year_next       = year;
    month_next      = month;
    day_next        = day;
    hour_next       = hour;
    minute_next     = minute;
    second_next     = second;
    millis_next     = millis;
    fields_bad_next = fields_bad;
    millis_bad_next = millis_bad;
    case (pos) inside
      5'd0, 5'd1, 5'd2, 5'd3: begin
        if (dig) year_next = 14'(year * 14'd10 + 14'(d));
        else fields_bad_next = 1'b1;
      end
      5'd5, 5'd6: begin
        if (dig) month_next = 7'(month * 7'd10 + 7'(d));
        else fields_bad_next = 1'b1;
      end
      5'd8, 5'd9: begin
        if (dig) day_next = 7'(day * 7'd10 + 7'(d));
        else fields_bad_next = 1'b1;
      end
      5'd11, 5'd12: begin
        if (dig) hour_next = 7'(hour * 7'd10 + 7'(d));
        else fields_bad_next = 1'b1;
      end
      5'd14, 5'd15: begin
        if (dig) minute_next = 7'(minute * 7'd10 + 7'(d));
        else fields_bad_next = 1'b1;
      end
      5'd17, 5'd18: begin
        if (dig) second_next = 7'(second * 7'd10 + 7'(d));
        else fields_bad_next = 1'b1;
      end
      5'd4, 5'd7: begin
        if (req.char_in != CH_DASH) fields_bad_next = 1'b1;
      end
      5'd10: begin
        if (req.char_in != CH_T) fields_bad_next = 1'b1;
      end
      5'd13, 5'd16: begin
        if (req.char_in != CH_COLON) fields_bad_next = 1'b1;
      end
      5'd19: begin
        if (req.char_in != CH_DOT) millis_bad_next = 1'b1;
      end
      5'd20, 5'd21, 5'd22: begin
        if (dig) millis_next = 10'(millis * 10'd10 + 10'(d));
        else millis_bad_next = 1'b1;
      end
      default: ;
    endcase
  end

  // last char sits at 19 or 23, so the stored accumulators are final here
  assign long_form    = (pos == POS_LAST_LONG);
  assign mil          = long_form ? millis : 10'd0;
  assign out_of_range = (month < 7'd1) || (month > 7'd12) || (day < 7'd1) || (day > 7'd31) ||
                        (hour > 7'd23) || (minute > 7'd59) || (second > 7'd59) ||
                        (mil > 10'd999);

  always_comb begin
    if (pos != POS_LAST_SHORT && pos != POS_LAST_LONG) err = ERR_LENGTH;
    else if (fields_bad) err = ERR_FIELDS;
    else if (long_form && millis_bad) err = ERR_MILLIS;
    else if (req.char_in != CH_Z) err = ERR_NO_Z;
    else if (out_of_range) err = ERR_RANGE;
    else err = ERR_OK;
  end

  assign push             = accept && req.is_last;
  assign push_data.err    = err;
  assign push_data.year   = year;
  assign push_data.month  = month[3:0];
  assign push_data.day    = day[4:0];
  assign push_data.hour   = hour[4:0];
  assign push_data.minute = minute[5:0];
  assign push_data.second = second[5:0];
  assign push_data.millis = mil;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      pos        <= '0;
      year       <= '0;
      month      <= '0;
      day        <= '0;
      hour       <= '0;
      minute     <= '0;
      second     <= '0;
      millis     <= '0;
      fields_bad <= 1'b0;
      millis_bad <= 1'b0;
    end else if (accept) begin
      pos        <= pos_next;
      year       <= year_next;
      month      <= month_next;
      day        <= day_next;
      hour       <= hour_next;
      minute     <= minute_next;
      second     <= second_next;
      millis     <= millis_next;
      fields_bad <= fields_bad_next;
      millis_bad <= millis_bad_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/iutc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module iutc_queue
  import iutc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_data,
  input  wire logic   pop,
  output entry_t      pop_data,
  output logic        full,
  output logic        empty
);

  entry_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/iutc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module iutc_back
  import iutc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire entry_t   pop_data,
  input  wire logic     q_empty,
  output logic          pop,
  iutc_result_if.source rsp
);

  back_state_t state, state_next;

  entry_t             ent;
  logic [13:0]        vshift;
  logic [25:0]        recip_prod;
  logic [26:0]        hour_ms;
  logic [21:0]        minute_ms;
  logic [15:0]        second_ms;
  logic [8:0]         yoe;
  logic [8:0]         doy;
  logic signed [23:0] era_days;
  logic [26:0]        ms_sum;
  logic [17:0]        doe;
  err_t               err_r;
  logic signed [22:0] days_r;
  logic [26:0]        ms_r;

  logic [4:0]         quot;
  logic signed [23:0] era;
  logic [3:0]         mp;
  logic [1:0]         cent;
  logic signed [23:0] days_full;

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = (pop_data.err == ERR_OK) ? B_DIV : B_OUT;
        end
      end
      B_DIV: state_next = B_REM;
      B_REM: state_next = B_DOE;
      B_DOE: state_next = B_SUM;
      B_SUM: state_next = B_OUT;
      B_OUT: begin
        if (rsp.ready) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  assign quot      = recip_prod[25:RECIP_SHIFT];
  assign era       = $signed({19'd0, quot}) - 24'sd1;
  assign mp        = (ent.month > 4'd2) ? ent.month - 4'd3 : ent.month + 4'd9;
  assign cent      = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
  assign days_full = era_days + $signed({6'd0, doe}) - 24'sd719468;

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        ent    <= pop_data;
        err_r  <= pop_data.err;
        // shifted year is y + 400, with y the March-based year
        vshift <= (pop_data.month <= 4'd2) ? pop_data.year + 14'd399 : pop_data.year + 14'd400;
        days_r <= '0;
        ms_r   <= '0;
      end
      B_DIV: begin
        recip_prod <= 26'(vshift * RECIP_400);
        hour_ms    <= 27'(ent.hour * 27'd3600000);
        minute_ms  <= 22'(ent.minute * 22'd60000);
        second_ms  <= 16'(ent.second * 16'd1000);
      end
      B_REM: begin
        yoe      <= 9'(vshift - 14'(quot * 14'd400));
        era_days <= 24'(era * 24'sd146097);
        doy      <= month_offset(mp) + 9'(ent.day) - 9'd1;
        ms_sum   <= hour_ms + 27'(minute_ms) + 27'(second_ms) + 27'(ent.millis);
      end
      B_DOE: begin
        doe <= 18'(yoe * 18'd365) + 18'(yoe[8:2]) - 18'(cent) + 18'(doy);
      end
      B_SUM: begin
        days_r <= days_full[22:0];
        ms_r   <= ms_sum;
      end
      B_OUT: ;
      default: ;
    endcase
  end

  assign rsp.valid            = (state == B_OUT);
  assign rsp.error_code       = err_r;
  assign rsp.days_since_epoch = days_r;
  assign rsp.ms_of_day        = ms_r;

endmodule

`default_nettype wire

// ===== rtl/iso8601_utc_instant_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// ISO-8601 UTC timestamp parser. Characters of YYYY-MM-DDTHH:MM:SSZ or
// YYYY-MM-DDTHH:MM:SS.mmmZ arrive one word per cycle on req, the final one
// flagged by is_last; each string yields one word on rsp with an error code,
// days since 1970-01-01 and milliseconds of the day (both zero on error).
// The front parser takes one character every cycle; a two-entry queue holds
// finished strings for the calendar unit, which runs four arithmetic steps
// on a valid string after dequeuing it, presents a rejected one directly,
// and holds each result until rsp.ready. req.ready drops only while the
// queue holds two strings, so with rsp.ready held high the sustained rate
// is one character per cycle for strings of 20 or more characters.
module iso8601_utc_instant_parser_unit
  import iutc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  iutc_char_if.sink     req,
  iutc_result_if.source rsp
);

  entry_t push_data;
  entry_t pop_data;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;

  iutc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .push_data (push_data),
    .push      (push),
    .q_full    (q_full)
  );

  iutc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  iutc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_data (pop_data),
    .q_empty  (q_empty),
    .pop      (pop),
    .rsp      (rsp)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_full && !pop))
    else $error("queue overflow");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.error_code != ERR_OK |-> rsp.days_since_epoch == '0 && rsp.ms_of_day == '0)
    else $error("error word carries nonzero result");

  a_ms_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.error_code == ERR_OK |-> rsp.ms_of_day < 27'd86400000)
    else $error("ms_of_day out of range");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ready |=> !rsp.valid)
    else $error("result word repeated");

endmodule

`default_nettype wire
